>>> sv/kmd_pkg.sv
// Package for the keypad matrix debouncer.
// Matrix geometry, counter widths and the per-key result type; no dependencies.
`timescale 1ns / 1ps

package kmd_pkg;

  localparam int NUM_ROWS    = 4;
  localparam int NUM_COLS    = 4;
  localparam int KEY_SLOTS   = 16;
  localparam int MATRIX_KEYS = NUM_ROWS * NUM_COLS;
  localparam int ACTIVE_KEYS = (MATRIX_KEYS < KEY_SLOTS) ? MATRIX_KEYS : KEY_SLOTS;
  localparam int CNT_W       = 4;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(3);

  typedef logic [KEY_SLOTS-1:0] key_vec_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic stable;
    logic press;
    logic release_ev;
  } lane_res_t;

endpackage

>>> sv/kmd_lane.sv
// One key debouncer: stable state and counter, updated on each input transfer.
// Depends on kmd_pkg.
`timescale 1ns / 1ps

module kmd_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              xfer,
  input  logic              raw,
  input  kmd_pkg::cnt_t     dcount,
  output kmd_pkg::lane_res_t res
);

  logic                  stable_r, stable_nxt;
  kmd_pkg::cnt_t         cnt_r, cnt_nxt;
  logic [kmd_pkg::CNT_W:0] cnt_inc;
  logic                  flip;

  always_comb begin
    cnt_inc    = {1'b0, cnt_r} + (kmd_pkg::CNT_W+1)'(1);
    flip       = 1'b0;
    stable_nxt = stable_r;
    cnt_nxt    = '0;
    if (raw != stable_r) begin
      if (cnt_inc >= {1'b0, dcount}) begin
        flip       = 1'b1;
        stable_nxt = raw;
      end else begin
        cnt_nxt = cnt_inc[kmd_pkg::CNT_W-1:0];
      end
    end
    res.stable     = stable_nxt;
    res.press      = flip & raw;
    res.release_ev = flip & ~raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      cnt_r    <= '0;
    end else if (xfer) begin
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> sv/kmd_merge.sv
// Merge stage: gathers the lane results into the registered result channel.
// Depends on kmd_pkg.
`timescale 1ns / 1ps

module kmd_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   xfer,
  input  kmd_pkg::lane_res_t [kmd_pkg::KEY_SLOTS-1:0] lane_res,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output kmd_pkg::key_vec_t                      key_state,
  output kmd_pkg::key_vec_t                      press_events,
  output kmd_pkg::key_vec_t                      release_events
);

  logic              valid_r, valid_nxt;
  kmd_pkg::key_vec_t state_r, press_r, release_r;
  kmd_pkg::key_vec_t state_nxt, press_nxt, release_nxt;

  always_comb begin
    for (int k = 0; k < kmd_pkg::KEY_SLOTS; k++) begin
      state_nxt[k]   = lane_res[k].stable;
      press_nxt[k]   = lane_res[k].press;
      release_nxt[k] = lane_res[k].release_ev;
    end
    valid_nxt = xfer | (valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      state_r   <= state_nxt;
      press_r   <= press_nxt;
      release_r <= release_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign key_state      = state_r;
  assign press_events   = press_r;
  assign release_events = release_r;

endmodule

>>> sv/keypad_matrix_debouncer.sv
// Keypad matrix debouncer: one snapshot in, stable states and edge masks out.
// The result is registered and appears in the cycle after the input transfer; throughput
// 1 snapshot per cycle while the output is not stalled.
// Input stalls only while the result register holds an untaken result.
// Synchronous active-low reset clears all key states, counters and the result
// valid, and sets debounce_count to 3. Depends on kmd_pkg, kmd_lane, kmd_merge.
`timescale 1ns / 1ps

module keypad_matrix_debouncer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  kmd_pkg::key_vec_t        in_raw_keys,
  output logic                     out_valid,
  input  logic                     out_stall,
  output kmd_pkg::key_vec_t        out_key_state,
  output kmd_pkg::key_vec_t        out_press_events,
  output kmd_pkg::key_vec_t        out_release_events,
  input  logic                     cfg_wr_en,
  input  kmd_pkg::cnt_t            cfg_wr_data
);

  kmd_pkg::cnt_t                               dcount_r;
  logic                                        in_xfer;
  kmd_pkg::lane_res_t [kmd_pkg::KEY_SLOTS-1:0] lane_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcount_r <= kmd_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      dcount_r <= cfg_wr_data;
    end
  end

  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  for (genvar k = 0; k < kmd_pkg::KEY_SLOTS; k++) begin : g_lane
    if (k < kmd_pkg::ACTIVE_KEYS) begin : g_act
      kmd_lane u_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .xfer   (in_xfer),
        .raw    (in_raw_keys[k]),
        .dcount (dcount_r),
        .res    (lane_res[k])
      );
    end else begin : g_off
      assign lane_res[k] = '0;
    end
  end

  kmd_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .xfer           (in_xfer),
    .lane_res       (lane_res),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .key_state      (out_key_state),
    .press_events   (out_press_events),
    .release_events (out_release_events)
  );

endmodule

>>> test/keypad_debounce_checker.sv
// Checker for the keypad matrix debouncer: watches the snapshot, result and config ports,
// predicts each result and compares it field by field. Depends on kmd_pkg.
`timescale 1ns / 1ps

module keypad_debounce_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  kmd_pkg::key_vec_t in_raw_keys,
  input  logic              out_valid,
  input  logic              out_stall,
  input  kmd_pkg::key_vec_t out_key_state,
  input  kmd_pkg::key_vec_t out_press_events,
  input  kmd_pkg::key_vec_t out_release_events,
  input  logic              cfg_wr_en,
  input  kmd_pkg::cnt_t     cfg_wr_data,
  output int                err_count,
  output int                open_count
);

  typedef struct packed {
    kmd_pkg::key_vec_t state;
    kmd_pkg::key_vec_t pressed;
    kmd_pkg::key_vec_t released;
  } scan_res_t;

  scan_res_t         scan_q[$];
  kmd_pkg::key_vec_t deb_stable;
  kmd_pkg::cnt_t     deb_cnt [kmd_pkg::KEY_SLOTS];
  kmd_pkg::cnt_t     deb_limit;
  int                errs = 0;

  assign err_count = errs;

  function automatic scan_res_t debounce_tick(input kmd_pkg::key_vec_t raw);
    scan_res_t               r;
    logic [kmd_pkg::CNT_W:0] nxt;
    int                      k;
    r = '0;
    for (k = 0; k < kmd_pkg::ACTIVE_KEYS; k++) begin
      if (raw[k] != deb_stable[k]) begin
        nxt = {1'b0, deb_cnt[k]} + 1'b1;
        if (nxt >= {1'b0, deb_limit}) begin
          deb_cnt[k]    = '0;
          deb_stable[k] = raw[k];
          if (raw[k]) r.pressed[k] = 1'b1;
          else r.released[k] = 1'b1;
        end else begin
          deb_cnt[k] = nxt[kmd_pkg::CNT_W-1:0];
        end
      end else begin
        deb_cnt[k] = '0;
      end
    end
    r.state = deb_stable;
    return r;
  endfunction

  task automatic check_field(input string fname, input kmd_pkg::key_vec_t want,
                             input kmd_pkg::key_vec_t got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", fname, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    scan_res_t want;
    if (!rst_n) begin
      deb_stable = '0;
      foreach (deb_cnt[k]) deb_cnt[k] = '0;
      deb_limit = kmd_pkg::DEBOUNCE_RESET;
      scan_q.delete();
    end else begin
      if (cfg_wr_en) deb_limit = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (scan_q.size() == 0) begin
          $error("result transfer with no result expected");
          errs++;
        end else begin
          want = scan_q.pop_front();
          check_field("key_state", want.state, out_key_state);
          check_field("press_events", want.pressed, out_press_events);
          check_field("release_events", want.released, out_release_events);
        end
      end
      if (in_valid && !in_stall) scan_q.push_back(debounce_tick(in_raw_keys));
    end
    open_count <= scan_q.size();
  end

endmodule

>>> test/tb_keypad_matrix_debouncer.sv
// Testbench top for keypad_matrix_debouncer: drives reset, config writes and snapshots,
// stalls the result side, and reports the verdict. Depends on kmd_pkg, the debouncer and the checker.
`timescale 1ns / 1ps

module tb_keypad_matrix_debouncer;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  kmd_pkg::key_vec_t in_raw_keys = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  kmd_pkg::key_vec_t out_key_state;
  kmd_pkg::key_vec_t out_press_events;
  kmd_pkg::key_vec_t out_release_events;
  logic              cfg_wr_en = 1'b0;
  kmd_pkg::cnt_t     cfg_wr_data = kmd_pkg::DEBOUNCE_RESET;
  int                err_count;
  int                open_count;

  int burst_left = 0;
  int limit_now = int'(kmd_pkg::DEBOUNCE_RESET);
  int stall_mode = 0;
  int stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keypad_matrix_debouncer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_keys        (in_raw_keys),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_key_state      (out_key_state),
    .out_press_events   (out_press_events),
    .out_release_events (out_release_events),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  keypad_debounce_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_keys        (in_raw_keys),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_key_state      (out_key_state),
    .out_press_events   (out_press_events),
    .out_release_events (out_release_events),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .err_count          (err_count),
    .open_count         (open_count)
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_left % 16 < 12);
    endcase
  end

  task automatic send_scan(input kmd_pkg::key_vec_t raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_raw_keys <= raw;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every result is back, then let the pipeline drain
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_limit(input kmd_pkg::cnt_t val);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_now = int'(val);
  endtask

  task automatic repeat_scan(input kmd_pkg::key_vec_t raw, input int n);
    repeat (n) send_scan(raw);
  endtask

  task automatic random_scans(input int n_scans);
    kmd_pkg::key_vec_t target;
    kmd_pkg::key_vec_t raw;
    int                hold_len;
    int                sent;
    sent   = 0;
    target = '0;
    while (sent < n_scans) begin
      case ($urandom_range(0, 3))
        0: target = kmd_pkg::key_vec_t'($urandom);
        1: target = target ^ (kmd_pkg::key_vec_t'(1) << $urandom_range(0, 15));
        2: target = target ^ (kmd_pkg::key_vec_t'($urandom) & kmd_pkg::key_vec_t'($urandom));
        default: target = $urandom_range(0, 1) ? '1 : '0;
      endcase
      hold_len = $urandom_range(1, limit_now + 2);
      repeat (hold_len) begin
        raw = target;
        if ($urandom_range(0, 9) == 0)
          raw = raw ^ (kmd_pkg::key_vec_t'(1) << $urandom_range(0, 15));
        send_scan(raw);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset count of three: full press, bounce that clears counters, full release
    send_scan('0);
    repeat_scan('1, 3);
    send_scan('1);
    repeat_scan('0, 2);
    send_scan('1);
    repeat_scan('0, 3);
    repeat_scan(16'hA5A5, 3);
    send_scan(16'h5A5A);
    repeat_scan(16'h8001, 3);
    repeat_scan('0, 3);

    set_limit(kmd_pkg::cnt_t'(1));
    random_scans(260);
    set_limit(kmd_pkg::cnt_t'(15));
    random_scans(240);
    set_limit(kmd_pkg::cnt_t'(0));
    random_scans(200);

    // lower the count while keys are partway through debouncing
    set_limit(kmd_pkg::cnt_t'(1));
    send_scan('0);
    set_limit(kmd_pkg::cnt_t'(15));
    repeat_scan('1, 9);
    set_limit(kmd_pkg::cnt_t'(5));
    send_scan('1);
    repeat_scan('0, 4);
    set_limit(kmd_pkg::cnt_t'(3));
    send_scan('0);

    repeat (5) begin
      set_limit(kmd_pkg::cnt_t'($urandom_range(0, 15)));
      random_scans(240);
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
sv/kmd_pkg.sv
sv/kmd_lane.sv
sv/kmd_merge.sv
sv/keypad_matrix_debouncer.sv
test/keypad_debounce_checker.sv
test/tb_keypad_matrix_debouncer.sv
